// ----- src/sorted_note_set_assert.svh -----
// Assertion macros for the sorted note set.
`ifndef SORTED_NOTE_SET_ASSERT_SVH
`define SORTED_NOTE_SET_ASSERT_SVH

`ifndef SYNTHESIS
`define SNS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SNS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SNS_ASSERT(lbl, prop, msg)
`define SNS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- src/sns_pkg.sv -----
// Types and constants of the sorted note set.
`default_nettype none

package sns_pkg;

	localparam int MAX_NOTES_DEF = 64;

	localparam int NOTE_W  = 7;
	localparam int VEL_W   = 7;
	localparam int COUNT_W = 7;
	localparam int ACT_W   = 2;
	localparam int STAT_W  = 2;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	localparam int OUT_NOTE_LO = 0;
	localparam int OUT_VEL_LO  = OUT_NOTE_LO + NOTE_W;
	localparam int OUT_HC_LO   = OUT_VEL_LO + VEL_W;
	localparam int OUT_ST_LO   = OUT_HC_LO + COUNT_W;

	typedef enum logic [ACT_W-1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_DUMP   = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_HELD      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

endpackage

`default_nettype wire

// ----- src/sorted_note_set.sv -----
// Add and remove scan the entries in order, then shift entries up or down to open or close a gap;
// the result is loaded once the update is done, and waits while the output is held.
// Clear and an empty dump load their result directly; a dump reads and loads its entries one at a time.
// Throughput: one request in flight; the next is taken the cycle after its last result is loaded.
// Reset clears the state machine, the entry count and the output valid.
// The table memory is not cleared; only entries below the count are ever read.
`default_nettype none

module sorted_note_set #(
	parameter int MAX_NOTES = sns_pkg::MAX_NOTES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// [6:0] note, [13:7] velocity, [15:14] zero
	input  wire logic [sns_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// [1:0] action
	input  wire logic [sns_pkg::ACT_W-1:0]      s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// [6:0] out_note, [13:7] out_velocity, [20:14] held_count, [22:21] status, [23] zero
	output logic [sns_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// [0] has_entry
	output logic                                m_axis_tuser,
	output logic                                m_axis_tlast
);

	import sns_pkg::*;

	`include "sorted_note_set_assert.svh"

	localparam int AW    = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
	localparam int CW    = $clog2(MAX_NOTES + 1);
	localparam int ENT_W = NOTE_W + VEL_W;
	localparam logic [CW-1:0] ONE     = CW'(1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_NOTES);

	typedef enum logic [9:0] {
		S_IDLE      = 10'b00_0000_0001,
		S_SCAN_RD   = 10'b00_0000_0010,
		S_SCAN_CHK  = 10'b00_0000_0100,
		S_SHUP_RD   = 10'b00_0000_1000,
		S_SHUP_WR   = 10'b00_0001_0000,
		S_SHDN_RD   = 10'b00_0010_0000,
		S_SHDN_WR   = 10'b00_0100_0000,
		S_DUMP_RD   = 10'b00_1000_0000,
		S_DUMP_WAIT = 10'b01_0000_0000,
		S_EMIT      = 10'b10_0000_0000
	} state_t;

	state_t              state_q, state_d;
	action_t             act_q, act_d;
	status_t             status_q, status_d;
	logic [NOTE_W-1:0]   note_q, note_d;
	logic [VEL_W-1:0]    vel_q, vel_d;
	logic [CW-1:0]       idx_q, idx_d;
	logic [CW-1:0]       pos_q, pos_d;
	logic [CW-1:0]       count_q, count_d;
	logic [CW-1:0]       idx_inc, idx_dec;

	logic [ENT_W-1:0]    mem [MAX_NOTES];
	logic [ENT_W-1:0]    rd_data_q;
	logic                mem_re, mem_we;
	logic [AW-1:0]       mem_ra, mem_wa;
	logic [ENT_W-1:0]    mem_wd;
	logic [NOTE_W-1:0]   rd_note;

	logic                m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_data_q, out_data;
	logic                m_user_q, m_last_q;
	logic                out_free, out_load;
	logic                out_has, out_last;

	assign idx_inc  = idx_q + ONE;
	assign idx_dec  = idx_q - ONE;
	assign rd_note  = rd_data_q[NOTE_W-1:0];
	assign out_free = !m_tvalid_q || m_axis_tready;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tlast  = m_last_q;

	always_comb begin
		state_d  = state_q;
		act_d    = act_q;
		status_d = status_q;
		note_d   = note_q;
		vel_d    = vel_q;
		idx_d    = idx_q;
		pos_d    = pos_q;
		count_d  = count_q;
		mem_re   = 1'b0;
		mem_ra   = idx_q[AW-1:0];
		mem_we   = 1'b0;
		mem_wa   = idx_q[AW-1:0];
		mem_wd   = rd_data_q;
		out_load = 1'b0;
		out_has  = 1'b0;
		out_last = 1'b1;
		out_data = '0;
		out_data[OUT_ST_LO +: STAT_W] = status_q;
		out_data[OUT_HC_LO +: COUNT_W] = COUNT_W'(count_q);
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					act_d    = action_t'(s_axis_tuser);
					note_d   = s_axis_tdata[NOTE_W-1:0];
					vel_d    = s_axis_tdata[NOTE_W +: VEL_W];
					idx_d    = '0;
					status_d = ST_OK;
					unique case (action_t'(s_axis_tuser))
						ACT_CLEAR: begin
							count_d = '0;
							state_d = S_EMIT;
						end
						ACT_DUMP: state_d = (count_q == '0) ? S_EMIT : S_DUMP_RD;
						default:  state_d = S_SCAN_RD;
					endcase
				end
			end
			S_SCAN_RD: begin
				if (idx_q == count_q) begin
					if (act_q == ACT_ADD) begin
						pos_d = count_q;
						if (count_q == MAX_CNT) begin
							status_d = ST_FULL;
							state_d  = S_EMIT;
						end else begin
							state_d = S_SHUP_RD;
						end
					end else begin
						status_d = ST_NOT_FOUND;
						state_d  = S_EMIT;
					end
				end else begin
					mem_re  = 1'b1;
					state_d = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				if (act_q == ACT_ADD) begin
					if (rd_note == note_q) begin
						status_d = ST_HELD;
						state_d  = S_EMIT;
					end else if (rd_note > note_q) begin
						pos_d = idx_q;
						if (count_q == MAX_CNT) begin
							status_d = ST_FULL;
							state_d  = S_EMIT;
						end else begin
							idx_d   = count_q;
							state_d = S_SHUP_RD;
						end
					end else begin
						idx_d   = idx_inc;
						state_d = S_SCAN_RD;
					end
				end else if (rd_note == note_q) begin
					state_d = S_SHDN_RD;
				end else begin
					idx_d   = idx_inc;
					state_d = S_SCAN_RD;
				end
			end
			S_SHUP_RD: begin
				if (idx_q == pos_q) begin
					mem_we  = 1'b1;
					mem_wd  = {vel_q, note_q};
					count_d = count_q + ONE;
					state_d = S_EMIT;
				end else begin
					mem_re  = 1'b1;
					mem_ra  = idx_dec[AW-1:0];
					state_d = S_SHUP_WR;
				end
			end
			S_SHUP_WR: begin
				mem_we  = 1'b1;
				idx_d   = idx_dec;
				state_d = S_SHUP_RD;
			end
			S_SHDN_RD: begin
				if (idx_inc == count_q) begin
					count_d = count_q - ONE;
					state_d = S_EMIT;
				end else begin
					mem_re  = 1'b1;
					mem_ra  = idx_inc[AW-1:0];
					state_d = S_SHDN_WR;
				end
			end
			S_SHDN_WR: begin
				mem_we  = 1'b1;
				idx_d   = idx_inc;
				state_d = S_SHDN_RD;
			end
			S_DUMP_RD: begin
				mem_re  = 1'b1;
				state_d = S_DUMP_WAIT;
			end
			S_DUMP_WAIT: begin
				out_has  = 1'b1;
				out_last = (idx_inc == count_q);
				out_data[OUT_NOTE_LO +: NOTE_W] = rd_note;
				out_data[OUT_VEL_LO +: VEL_W]   = rd_data_q[NOTE_W +: VEL_W];
				out_data[OUT_ST_LO +: STAT_W]   = ST_OK;
				if (out_free) begin
					out_load = 1'b1;
					if (out_last) begin
						state_d = S_IDLE;
					end else begin
						idx_d   = idx_inc;
						state_d = S_DUMP_RD;
					end
				end
			end
			S_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		act_q    <= act_d;
		status_q <= status_d;
		note_q   <= note_d;
		vel_q    <= vel_d;
		idx_q    <= idx_d;
		pos_q    <= pos_d;
		if (out_load) begin
			m_data_q <= out_data;
			m_user_q <= out_has;
			m_last_q <= out_last;
		end
	end

	// table memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_ra];
		end
	end

	`SNS_ASSERT(a_count_bound, count_q <= MAX_CNT, "entry count beyond table depth")
	`SNS_ASSERT(a_entry_fields, (m_tvalid_q && m_user_q) |-> (m_data_q[OUT_HC_LO +: COUNT_W] != '0 && m_data_q[OUT_ST_LO +: STAT_W] == ST_OK), "dumped entry with empty count or bad status")
	`SNS_ASSERT(a_write_in_range, mem_we |-> (CW'(mem_wa) <= count_q), "table write beyond held entries")
	`SNS_ASSERT_NEXT(a_count_steady, state_q != S_IDLE && state_q != S_SHUP_RD && state_q != S_SHDN_RD, $stable(count_q), "entry count changed outside update points")

endmodule

`default_nettype wire
